FILE: rtl/core/first_fit_heap_allocator_top_macros.svh
// Assertion macros for the checker file of the allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned REQ_W    = 16;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned MIN_SPLIT_DATA = 8;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TAIL,
    WR_HEAD,
    WR_USE,
    WR_BLK,
    WR_MERGE
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_KEEP,
    RES_BLOCK,
    RES_ADDR
  } res_sel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_A_RD,
    S_A_CAP,
    S_A_EVAL,
    S_A_TAIL,
    S_A_HEAD,
    S_F_RD,
    S_F_CAP,
    S_F_EVAL,
    S_R_TAIL,
    S_R_HEAD,
    S_FREE_BLK,
    S_M_RD,
    S_M_CAP,
    S_M_NX,
    S_M_NCAP,
    S_M_EVAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic     load;
    logic     rd;
    logic     rd_nx;
    logic     cap_cur;
    logic     cap_nx;
    logic     adv;
    logic     adv_nx;
    logic     pos_zero;
    logic     set_blk;
    wr_sel_e  wr_sel;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic size_zero;
    logic addr_zero;
    logic end_pos;
    logic cur_free;
    logic fits;
    logic split_ok;
    logic match;
    logic nx_end;
    logic nx_free;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/core/ffha_dp.sv
`timescale 1ns / 1ps
module ffha_dp #(
  parameter int unsigned HEAP_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ffha_pkg::OP_W-1:0]           op_i,
  input  logic [ffha_pkg::REQ_W-1:0]          request_size_i,
  input  logic [ffha_pkg::ADDR_W-1:0]         block_address_i,
  input  logic                                out_stall_i,
  input  ffha_pkg::cmd_t                      cmd_i,
  output ffha_pkg::status_t                   sts_o,
  output logic                                out_valid_o,
  output logic [ffha_pkg::ADDR_W-1:0]         result_address_o,
  output logic                                granted_o
);

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned SW = AW;
  localparam int unsigned CW = ((AW > 17) ? AW : 17) + 2;

  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] ALN_C  = CW'(ALIGN_BYTES);
  localparam logic [CW-1:0] MIN_C  = CW'(ffha_pkg::MIN_SPLIT_DATA);
  localparam logic [SW-1:0] SIZE0_RST = SW'(HEAP_BYTES - HEADER_BYTES);

  // Headers live at byte offsets, so the store is indexed by byte offset.
  logic [SW:0]   mem_q [HEAP_BYTES];
  logic [SW:0]   rd_data_q;
  logic          rd_zero_q;
  logic [SW-1:0] size0_q;
  logic          free0_q;

  ffha_pkg::op_e op_q;
  logic [CW-1:0] need_q;
  logic          size_zero_q;
  logic [CW-1:0] addr_q;
  logic [PW-1:0] pos_q;
  logic [SW-1:0] cur_size_q;
  logic          cur_free_q;
  logic [SW-1:0] nx_size_q;
  logic          nx_free_q;
  logic [AW-1:0] blk_q;
  logic [SW-1:0] blk_size_q;
  logic [PW-1:0] res_q;
  logic          out_valid_q;
  logic [PW-1:0] out_res_q;

  logic [CW-1:0] pos_c;
  logic [CW-1:0] cur_c;
  logic [CW-1:0] next_c;
  logic [CW-1:0] data_c;
  logic [CW-1:0] tail_pos_c;
  logic [CW-1:0] tail_size_c;
  logic [CW-1:0] merge_c;
  logic [CW-1:0] need_sum_c;
  logic [CW-1:0] need_c;
  logic [CW-1:0] res_ext_c;
  logic [AW-1:0] rd_idx;
  logic [SW:0]   rd_val;
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  logic [SW-1:0] wr_size;
  logic          wr_free;

  always_comb begin
    pos_c       = CW'(pos_q);
    cur_c       = CW'(cur_size_q);
    next_c      = pos_c + HDR_C + cur_c;
    data_c      = pos_c + HDR_C;
    tail_pos_c  = data_c + need_q;
    tail_size_c = cur_c - need_q - HDR_C;
    merge_c     = cur_c + CW'(nx_size_q) + HDR_C;
    need_sum_c  = CW'(request_size_i) + ALN_C - CW'(1);
    need_c      = (need_sum_c / ALN_C) * ALN_C;
    res_ext_c   = CW'(out_res_q);
    rd_idx      = cmd_i.rd_nx ? next_c[AW-1:0] : pos_q[AW-1:0];
    rd_val      = rd_zero_q ? {free0_q, size0_q} : rd_data_q;
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_idx  = pos_q[AW-1:0];
    wr_size = cur_size_q;
    wr_free = 1'b0;
    case (cmd_i.wr_sel)
      ffha_pkg::WR_TAIL: begin
        wr_idx  = tail_pos_c[AW-1:0];
        wr_size = tail_size_c[SW-1:0];
        wr_free = 1'b1;
      end
      ffha_pkg::WR_HEAD: begin
        wr_size = need_q[SW-1:0];
      end
      ffha_pkg::WR_USE: begin
        wr_size = cur_size_q;
      end
      ffha_pkg::WR_BLK: begin
        wr_idx  = blk_q;
        wr_size = blk_size_q;
        wr_free = 1'b1;
      end
      ffha_pkg::WR_MERGE: begin
        wr_size = merge_c[SW-1:0];
        wr_free = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= {wr_free, wr_size};
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  // Entry zero holds the initial heap block, so it keeps a reset copy in flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size0_q     <= SIZE0_RST;
      free0_q     <= 1'b1;
      rd_zero_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en && (wr_idx == '0)) begin
        size0_q <= wr_size;
        free0_q <= wr_free;
      end
      if (cmd_i.rd) begin
        rd_zero_q <= (rd_idx == '0);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= ffha_pkg::op_e'(op_i);
      need_q      <= need_c;
      size_zero_q <= (request_size_i == '0);
      addr_q      <= CW'(block_address_i);
      res_q       <= '0;
    end
    if (cmd_i.load || cmd_i.pos_zero) begin
      pos_q <= '0;
    end else if (cmd_i.adv) begin
      pos_q <= (next_c >= HEAP_C) ? PW'(HEAP_BYTES) : next_c[PW-1:0];
    end else if (cmd_i.adv_nx) begin
      pos_q <= next_c[PW-1:0];
    end
    if (cmd_i.cap_cur) begin
      cur_size_q <= rd_val[SW-1:0];
      cur_free_q <= rd_val[SW];
    end else if (cmd_i.adv_nx) begin
      cur_size_q <= nx_size_q;
      cur_free_q <= nx_free_q;
    end else if (cmd_i.wr_sel == ffha_pkg::WR_MERGE) begin
      cur_size_q <= merge_c[SW-1:0];
    end
    if (cmd_i.cap_nx) begin
      nx_size_q <= rd_val[SW-1:0];
      nx_free_q <= rd_val[SW];
    end
    if (cmd_i.set_blk) begin
      blk_q      <= pos_q[AW-1:0];
      blk_size_q <= cur_size_q;
    end
    case (cmd_i.res_sel)
      ffha_pkg::RES_BLOCK: res_q <= data_c[PW-1:0];
      ffha_pkg::RES_ADDR:  res_q <= addr_q[PW-1:0];
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_res_q <= res_q;
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.size_zero = size_zero_q;
    sts_o.addr_zero = (addr_q == '0);
    sts_o.end_pos   = (pos_c >= HEAP_C);
    sts_o.cur_free  = cur_free_q;
    sts_o.fits      = (cur_c >= need_q);
    sts_o.split_ok  = (cur_c >= need_q + HDR_C + MIN_C) && (tail_pos_c < HEAP_C);
    sts_o.match     = (data_c == addr_q);
    sts_o.nx_end    = (next_c >= HEAP_C);
    sts_o.nx_free   = nx_free_q;
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_ext_c[ffha_pkg::ADDR_W-1:0];
  assign granted_o        = (out_res_q != '0);

endmodule

FILE: rtl/core/ffha_ctrl.sv
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffha_pkg::status_t sts_i,
  output ffha_pkg::cmd_t    cmd_o
);

  ffha_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    logic realloc_move;
    realloc_move = (sts_i.op == ffha_pkg::OP_REALLOC) && !sts_i.addr_zero;
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ffha_pkg::S_IDLE);
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ffha_pkg::S_DISP;
        end
      end
      ffha_pkg::S_DISP: begin
        case (sts_i.op)
          ffha_pkg::OP_ALLOC: begin
            state_d = sts_i.size_zero ? ffha_pkg::S_DONE : ffha_pkg::S_A_RD;
          end
          ffha_pkg::OP_FREE: begin
            state_d = sts_i.addr_zero ? ffha_pkg::S_DONE : ffha_pkg::S_F_RD;
          end
          ffha_pkg::OP_REALLOC: begin
            if (!sts_i.addr_zero) begin
              state_d = ffha_pkg::S_F_RD;
            end else begin
              state_d = sts_i.size_zero ? ffha_pkg::S_DONE : ffha_pkg::S_A_RD;
            end
          end
          default: state_d = ffha_pkg::S_DONE;
        endcase
      end
      ffha_pkg::S_A_RD: begin
        if (sts_i.end_pos) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ffha_pkg::S_A_CAP;
        end
      end
      ffha_pkg::S_A_CAP: begin
        cmd_o.cap_cur = 1'b1;
        state_d       = ffha_pkg::S_A_EVAL;
      end
      ffha_pkg::S_A_EVAL: begin
        if (sts_i.cur_free && sts_i.fits) begin
          if (sts_i.split_ok) begin
            state_d = ffha_pkg::S_A_TAIL;
          end else begin
            cmd_o.wr_sel  = ffha_pkg::WR_USE;
            cmd_o.res_sel = ffha_pkg::RES_BLOCK;
            state_d = realloc_move ? ffha_pkg::S_FREE_BLK : ffha_pkg::S_DONE;
          end
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ffha_pkg::S_A_RD;
        end
      end
      ffha_pkg::S_A_TAIL: begin
        cmd_o.wr_sel = ffha_pkg::WR_TAIL;
        state_d      = ffha_pkg::S_A_HEAD;
      end
      ffha_pkg::S_A_HEAD: begin
        cmd_o.wr_sel  = ffha_pkg::WR_HEAD;
        cmd_o.res_sel = ffha_pkg::RES_BLOCK;
        state_d = realloc_move ? ffha_pkg::S_FREE_BLK : ffha_pkg::S_DONE;
      end
      ffha_pkg::S_F_RD: begin
        if (sts_i.end_pos) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ffha_pkg::S_F_CAP;
        end
      end
      ffha_pkg::S_F_CAP: begin
        cmd_o.cap_cur = 1'b1;
        state_d       = ffha_pkg::S_F_EVAL;
      end
      ffha_pkg::S_F_EVAL: begin
        if (sts_i.match) begin
          cmd_o.set_blk = 1'b1;
          if ((sts_i.op == ffha_pkg::OP_FREE) || sts_i.size_zero) begin
            state_d = ffha_pkg::S_FREE_BLK;
          end else if (sts_i.cur_free) begin
            state_d = ffha_pkg::S_DONE;
          end else if (sts_i.fits) begin
            if (sts_i.split_ok) begin
              state_d = ffha_pkg::S_R_TAIL;
            end else begin
              cmd_o.res_sel = ffha_pkg::RES_ADDR;
              state_d       = ffha_pkg::S_DONE;
            end
          end else begin
            // Too small: look for a new block, the old one is freed once a new one is found.
            cmd_o.pos_zero = 1'b1;
            state_d        = ffha_pkg::S_A_RD;
          end
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ffha_pkg::S_F_RD;
        end
      end
      ffha_pkg::S_R_TAIL: begin
        cmd_o.wr_sel = ffha_pkg::WR_TAIL;
        state_d      = ffha_pkg::S_R_HEAD;
      end
      ffha_pkg::S_R_HEAD: begin
        cmd_o.wr_sel  = ffha_pkg::WR_HEAD;
        cmd_o.res_sel = ffha_pkg::RES_ADDR;
        state_d       = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_FREE_BLK: begin
        cmd_o.wr_sel   = ffha_pkg::WR_BLK;
        cmd_o.pos_zero = 1'b1;
        state_d        = ffha_pkg::S_M_RD;
      end
      ffha_pkg::S_M_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ffha_pkg::S_M_CAP;
      end
      ffha_pkg::S_M_CAP: begin
        cmd_o.cap_cur = 1'b1;
        state_d       = ffha_pkg::S_M_NX;
      end
      ffha_pkg::S_M_NX: begin
        if (sts_i.nx_end) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          cmd_o.rd    = 1'b1;
          cmd_o.rd_nx = 1'b1;
          state_d     = ffha_pkg::S_M_NCAP;
        end
      end
      ffha_pkg::S_M_NCAP: begin
        cmd_o.cap_nx = 1'b1;
        state_d      = ffha_pkg::S_M_EVAL;
      end
      ffha_pkg::S_M_EVAL: begin
        // A merged block stays put so that its new neighbour is tried next.
        if (sts_i.cur_free && sts_i.nx_free) begin
          cmd_o.wr_sel = ffha_pkg::WR_MERGE;
        end else begin
          cmd_o.adv_nx = 1'b1;
        end
        state_d = ffha_pkg::S_M_NX;
      end
      ffha_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ffha_pkg::S_IDLE;
        end
      end
      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// Channel | Handshake                | Payload
// --------+--------------------------+------------------------------------------
// request | in_valid_i / in_stall_o  | op_i, request_size_i, block_address_i
// result  | out_valid_o / out_stall_i| result_address_o, granted_o
//
// One request is handled at a time; in_stall_o is high from acceptance until the
// result moves into the output register. Each block header visited goes through
// read, capture and decide steps on the header store, both in the header walk
// of a request and in the merge pass after a free. Reset leaves one free block
// covering the heap and needs no sweep.
// The output register lets a new request enter while the previous result is stalled.
module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ffha_pkg::OP_W-1:0]     op_i,
  input  logic [ffha_pkg::REQ_W-1:0]    request_size_i,
  input  logic [ffha_pkg::ADDR_W-1:0]   block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ffha_pkg::ADDR_W-1:0]   result_address_o,
  output logic                          granted_o
);

  ffha_pkg::cmd_t    cmd;
  ffha_pkg::status_t sts;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .result_address_o (result_address_o),
    .granted_o        (granted_o)
  );

endmodule

FILE: rtl/core/ffha_checker.sv
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_top_macros.svh"
module ffha_props (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ffha_pkg::ADDR_W-1:0] result_address_o,
  input logic                        granted_o
);

  `FFHA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(result_address_o) && $stable(granted_o), "stalled result transaction changed")
  `FFHA_ASSERT_IMP(a_null_result, clk_i, rst_ni, out_valid_o && !granted_o, result_address_o == '0, "refused transaction carries an address")
  `FFHA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second request taken before the first finished")

endmodule

bind first_fit_heap_allocator_top ffha_props u_ffha_props (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_address_o (result_address_o),
  .granted_o        (granted_o)
);
